>>> design/rbpe_pkg.sv
`default_nettype none

package rbpe_pkg;

   // field widths
   localparam int PIX_W       = 16;
   localparam int POS_W       = 16;
   localparam int MODE_W      = 3;
   localparam int ALPHA_W     = 8;
   localparam int LEN_W       = 15;
   localparam int WIDE_W      = 32;
   localparam int SCALE_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // ramp numerator 255*diff, diff below 2^16
   localparam int NUM_W          = 24;
   localparam int DIV_STEPS      = 4;
   localparam int DIV_STAGES     = NUM_W / DIV_STEPS;

   localparam logic [WIDE_W-1:0]  FIELD_MASK   = 32'h07e0f81f;
   localparam logic [ALPHA_W-1:0] OPACITY_FULL = 8'hff;
   localparam logic [ALPHA_W-1:0] ALPHA_ROUND  = 8'd4;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_COPY   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BLEND  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FILTER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COVER  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RASTER = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COMP_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPACITY     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_START  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_END    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_LENGTH = 3'd4;

   typedef enum logic [2:0] {
      ACT_SKIP,
      ACT_COPY,
      ACT_MIX,
      ACT_COVER,
      ACT_RAMP
   } action_type;

   typedef struct packed {
      logic        [MODE_W-1:0]  comp_mode;
      logic        [ALPHA_W-1:0] opacity;
      logic signed [POS_W-1:0]   ramp_start;
      logic signed [POS_W-1:0]   ramp_end;
      logic        [LEN_W-1:0]   ramp_length;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] src_pixel;
      logic [PIX_W-1:0] dst_pixel;
      action_type       action;
   } pix_item_type;

   function automatic logic [WIDE_W-1:0] spread(input logic [PIX_W-1:0] p);
      return {p, p} & FIELD_MASK;
   endfunction

   function automatic logic [PIX_W-1:0] fold(input logic [WIDE_W-1:0] r);
      logic [WIDE_W-1:0] m;
      m = r & FIELD_MASK;
      return m[WIDE_W-1:PIX_W] | m[PIX_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> design/rbpe_req_if.sv
`default_nettype none

interface rbpe_req_if;
   import rbpe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic        [PIX_W-1:0] src_pixel;
   logic        [PIX_W-1:0] dst_pixel;
   logic signed [POS_W-1:0] position;

   modport source (output valid, src_pixel, dst_pixel, position, input ready);
   modport sink   (input valid, src_pixel, dst_pixel, position, output ready);
endinterface

`default_nettype wire

>>> design/rbpe_rsp_if.sv
`default_nettype none

interface rbpe_rsp_if;
   import rbpe_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_pixel;
   logic             write_enable;

   modport source (output valid, out_pixel, write_enable, input ready);
   modport sink   (input valid, out_pixel, write_enable, output ready);
endinterface

`default_nettype wire

>>> design/rbpe_csr_if.sv
`default_nettype none

interface rbpe_csr_if;
   import rbpe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/rbpe_decode.sv
`default_nettype none

module rbpe_decode (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rbpe_pkg::cfg_type               cfg,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [rbpe_pkg::PIX_W-1:0]      in_src,
   input  wire logic [rbpe_pkg::PIX_W-1:0]      in_dst,
   input  wire logic signed [rbpe_pkg::POS_W-1:0] in_pos,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output rbpe_pkg::pix_item_type               out_item,
   output logic [rbpe_pkg::NUM_W-1:0]           out_num
);
   import rbpe_pkg::*;

   logic                 valid_ff;
   pix_item_type         item_ff, item_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [POS_W-1:0]     diff_u;
   logic                 src_zero;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_num   = num_ff;

   // ramp distance, within 0..65534 whenever the ramp is taken, so 16 bits hold it
   assign diff_u   = cfg.ramp_end - in_pos;
   assign src_zero = (in_src == '0);

   always_comb begin
      item_in.src_pixel = in_src;
      item_in.dst_pixel = in_dst;
      // 255*diff as (diff << 8) - diff
      num_in = {diff_u, {(NUM_W-POS_W){1'b0}}} - {{(NUM_W-POS_W){1'b0}}, diff_u};
      case (cfg.comp_mode)
         MODE_COPY: begin
            item_in.action = ACT_COPY;
         end
         MODE_BLEND, MODE_FILTER: begin
            if (cfg.opacity == '0 || (cfg.comp_mode == MODE_FILTER && src_zero))
               item_in.action = ACT_SKIP;
            else if (cfg.opacity == OPACITY_FULL)
               item_in.action = ACT_COPY;
            else
               item_in.action = ACT_MIX;
         end
         MODE_COVER: begin
            if (cfg.opacity == '0 || src_zero)
               item_in.action = ACT_SKIP;
            else if (cfg.opacity == OPACITY_FULL)
               item_in.action = ACT_COPY;
            else
               item_in.action = ACT_COVER;
         end
         MODE_RASTER: begin
            if (in_pos <= cfg.ramp_start)
               item_in.action = ACT_COPY;
            else if (in_pos <= cfg.ramp_end)
               item_in.action = ACT_RAMP;
            else
               item_in.action = ACT_SKIP;
         end
         default: begin
            item_in.action = ACT_COPY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (in_ready)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
         num_ff  <= num_in;
      end
   end

endmodule

`default_nettype wire

>>> design/rbpe_divider.sv
`default_nettype none

module rbpe_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [rbpe_pkg::LEN_W-1:0]     divisor,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire rbpe_pkg::pix_item_type         in_item,
   input  wire logic [rbpe_pkg::NUM_W-1:0]     in_num,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output rbpe_pkg::pix_item_type              out_item,
   output logic [rbpe_pkg::ALPHA_W-1:0]        out_quot
);
   import rbpe_pkg::*;

   // index 0 is the module input, index k+1 the output of stage k
   logic                 st_valid [DIV_STAGES+1];
   pix_item_type         st_item  [DIV_STAGES+1];
   logic [NUM_W-1:0]     st_num   [DIV_STAGES+1];
   logic [LEN_W-1:0]     st_rem   [DIV_STAGES+1];
   logic [ALPHA_W-1:0]   st_quot  [DIV_STAGES+1];
   logic                 st_go    [DIV_STAGES+1];

   assign st_valid[0] = in_valid;
   assign st_item[0]  = in_item;
   assign st_num[0]   = in_num;
   assign st_rem[0]   = '0;
   assign st_quot[0]  = '0;
   assign in_ready    = st_go[0];
   assign st_go[DIV_STAGES] = out_ready;

   assign out_valid = st_valid[DIV_STAGES];
   assign out_item  = st_item[DIV_STAGES];
   assign out_quot  = st_quot[DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic               valid_ff;
      pix_item_type       item_ff;
      logic [NUM_W-1:0]   num_ff, num_in;
      logic [LEN_W-1:0]   rem_ff, rem_in;
      logic [ALPHA_W-1:0] quot_ff, quot_in;

      assign st_go[k]       = !valid_ff || st_go[k+1];
      assign st_valid[k+1]  = valid_ff;
      assign st_item[k+1]   = item_ff;
      assign st_num[k+1]    = num_ff;
      assign st_rem[k+1]    = rem_ff;
      assign st_quot[k+1]   = quot_ff;

      // restoring division, DIV_STEPS quotient bits per stage, msb first
      always_comb begin
         logic [LEN_W:0] trial;
         num_in  = st_num[k];
         rem_in  = st_rem[k];
         quot_in = st_quot[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial  = {rem_in, num_in[NUM_W-1]};
            num_in = {num_in[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial   = trial - {1'b0, divisor};
               quot_in = {quot_in[ALPHA_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_in[ALPHA_W-2:0], 1'b0};
            end
            rem_in = trial[LEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset)
            valid_ff <= 1'b0;
         else if (st_go[k])
            valid_ff <= st_valid[k];
      end

      always_ff @(posedge clock) begin
         if (st_go[k] && st_valid[k]) begin
            item_ff <= st_item[k];
            num_ff  <= num_in;
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/rbpe_blend.sv
`default_nettype none

module rbpe_blend (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rbpe_pkg::ALPHA_W-1:0] opacity,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire rbpe_pkg::pix_item_type      in_item,
   input  wire logic [rbpe_pkg::ALPHA_W-1:0] in_quot,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [rbpe_pkg::PIX_W-1:0]       out_pixel,
   output logic                             out_we
);
   import rbpe_pkg::*;

   // stage a: alpha quantize, spread, difference
   logic               a_valid_ff;
   pix_item_type       a_item_ff;
   logic [WIDE_W-1:0]  a_delta_ff, a_delta_in;
   logic [WIDE_W-1:0]  a_bg_ff, a_bg_in;
   logic [SCALE_W-1:0] a_scale_ff, a_scale_in;
   logic [ALPHA_W-1:0] alpha;
   logic [ALPHA_W:0]   alpha_sum;
   logic               a_go;

   // stage b: product
   logic               b_valid_ff;
   pix_item_type       b_item_ff;
   logic [WIDE_W-1:0]  b_prod_ff, b_prod_in;
   logic [WIDE_W-1:0]  b_bg_ff;
   logic               b_go;

   // stage c: output register
   logic               c_valid_ff;
   logic [PIX_W-1:0]   c_pixel_ff, c_pixel_in;
   logic               c_we_ff, c_we_in;
   logic [WIDE_W-1:0]  c_sum;
   logic               c_go;

   assign c_go     = !c_valid_ff || out_ready;
   assign b_go     = !b_valid_ff || c_go;
   assign a_go     = !a_valid_ff || b_go;
   assign in_ready = a_go;

   assign out_valid = c_valid_ff;
   assign out_pixel = c_pixel_ff;
   assign out_we    = c_we_ff;

   always_comb begin
      alpha      = (in_item.action == ACT_RAMP) ? in_quot : opacity;
      alpha_sum  = {1'b0, alpha} + {1'b0, ALPHA_ROUND};
      a_scale_in = alpha_sum[ALPHA_W:ALPHA_W-SCALE_W+1];
      // cover scales toward black: background of zero
      a_bg_in    = (in_item.action == ACT_COVER) ? '0 : spread(in_item.dst_pixel);
      a_delta_in = spread(in_item.src_pixel) - a_bg_in;
   end

   assign b_prod_in = a_delta_ff * {{(WIDE_W-SCALE_W){1'b0}}, a_scale_ff};

   always_comb begin
      c_sum = (b_prod_ff >> 5) + b_bg_ff;
      case (b_item_ff.action)
         ACT_SKIP: begin
            c_pixel_in = b_item_ff.dst_pixel;
            c_we_in    = 1'b0;
         end
         ACT_COPY: begin
            c_pixel_in = b_item_ff.src_pixel;
            c_we_in    = 1'b1;
         end
         default: begin
            c_pixel_in = fold(c_sum);
            c_we_in    = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_go) a_valid_ff <= in_valid;
         if (b_go) b_valid_ff <= a_valid_ff;
         if (c_go) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && in_valid) begin
         a_item_ff  <= in_item;
         a_delta_ff <= a_delta_in;
         a_bg_ff    <= a_bg_in;
         a_scale_ff <= a_scale_in;
      end
      if (b_go && a_valid_ff) begin
         b_item_ff <= a_item_ff;
         b_prod_ff <= b_prod_in;
         b_bg_ff   <= a_bg_ff;
      end
      if (c_go && b_valid_ff) begin
         c_pixel_ff <= c_pixel_in;
         c_we_ff    <= c_we_in;
      end
   end

endmodule

`default_nettype wire

>>> design/rgb565_blend_pixel_engine_unit.sv
// pipeline: 10 register stages (1 decode, 6 divide, 3 blend), the last of them the
// output register; throughput: one item per cycle while rsp_ch.ready does not stall;
// the 24-bit ramp divide is a 6-stage pipeline at 4 quotient bits per stage, so no
// unit is shared between items
// reset: synchronous, active high; clears all stage valid bits and loads the
// register reset values (copy mode, opacity 255, ramp 0..0, length 1)
`default_nettype none

module rgb565_blend_pixel_engine_unit (
   input wire logic   clock,
   input wire logic   reset,
   rbpe_req_if.sink   req_ch,
   rbpe_rsp_if.source rsp_ch,
   rbpe_csr_if.sink   csr_ch
);
   import rbpe_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   // decode -> divider
   logic               dec_valid, dec_ready;
   pix_item_type       dec_item;
   logic [NUM_W-1:0]   dec_num;

   // divider -> blend
   logic               div_valid, div_ready;
   pix_item_type       div_item;
   logic [ALPHA_W-1:0] div_quot;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comp_mode   <= MODE_COPY;
         cfg_ff.opacity     <= OPACITY_FULL;
         cfg_ff.ramp_start  <= '0;
         cfg_ff.ramp_end    <= '0;
         cfg_ff.ramp_length <= LEN_W'(1);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_COMP_MODE:   cfg_ff.comp_mode  <= csr_ch.data[MODE_W-1:0];
            CSR_OPACITY:     cfg_ff.opacity    <= csr_ch.data[ALPHA_W-1:0];
            CSR_RAMP_START:  cfg_ff.ramp_start <= csr_ch.data[POS_W-1:0];
            CSR_RAMP_END:    cfg_ff.ramp_end   <= csr_ch.data[POS_W-1:0];
            CSR_RAMP_LENGTH: begin
               // a zero length divides as one
               if (csr_ch.data[LEN_W-1:0] == '0)
                  cfg_ff.ramp_length <= LEN_W'(1);
               else
                  cfg_ff.ramp_length <= csr_ch.data[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage 1: mode decode and ramp numerator
   rbpe_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_src    (req_ch.src_pixel),
      .in_dst    (req_ch.dst_pixel),
      .in_pos    (req_ch.position),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_item  (dec_item),
      .out_num   (dec_num)
   );

   // stages 2..7: ramp alpha quotient, low 8 bits kept
   rbpe_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .divisor   (cfg_ff.ramp_length),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_item   (dec_item),
      .in_num    (dec_num),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item),
      .out_quot  (div_quot)
   );

   // stages 8..10: spread, multiply, fold; last stage is the output register
   rbpe_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .opacity   (cfg_ff.opacity),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .in_quot   (div_quot),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_pixel (rsp_ch.out_pixel),
      .out_we    (rsp_ch.write_enable)
   );

endmodule

`default_nettype wire
